// ===== rtl/knp_pkg.sv =====
package knp_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumWords = 4;
	localparam int unsigned MaxKeyWords = 8;
	localparam int unsigned CfgW = 64;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned RoundW = 8;
	localparam int unsigned PhaseW = $clog2(NumWords);
	localparam int unsigned KeyIdxW = $clog2(MaxKeyWords);

	typedef logic [WordW-1:0] word_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_KEY_SIZE = 3'd0,
		CFG_KEY_A    = 3'd1,
		CFG_KEY_B    = 3'd2,
		CFG_KEY_C    = 3'd3,
		CFG_KEY_D    = 3'd4
	} cfg_idx_t;

	// key size codes
	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	localparam logic [KeyIdxW-1:0] LAST_KEY_128 = KeyIdxW'(3);
	localparam logic [KeyIdxW-1:0] LAST_KEY_192 = KeyIdxW'(5);
	localparam logic [KeyIdxW-1:0] LAST_KEY_256 = KeyIdxW'(7);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// sequencer to datapath
	typedef struct packed {
		logic               load;
		logic               step;
		logic               done;
		logic [PhaseW-1:0]  phase;
		logic [KeyIdxW-1:0] key_idx;
	} seq_ctl_t;

endpackage

// ===== rtl/knp_pass.sv =====
module knp_pass (
	input  knp_pkg::word_t              word0,
	input  knp_pkg::word_t              word1,
	input  knp_pkg::word_t              word2,
	input  knp_pkg::word_t              word3,
	input  logic [knp_pkg::PhaseW-1:0]  phase,
	input  knp_pkg::word_t              key_word,
	output knp_pkg::word_t              word_new
);
	import knp_pkg::*;

	word_t a, b, c, d;
	word_t t1, t2, t3, t4;

	// rotate word roles so the updated word is always a
	always_comb begin
		case (phase)
			2'd0: begin
				a = word0; b = word1; c = word2; d = word3;
			end
			2'd1: begin
				a = word1; b = word2; c = word3; d = word0;
			end
			2'd2: begin
				a = word2; b = word3; c = word0; d = word1;
			end
			default: begin
				a = word3; b = word0; c = word1; d = word2;
			end
		endcase
	end

	// 32 feedback steps at once
	assign t1 = (b >> 15) | (c << 17);
	assign t2 = (c >> 6) | (d << 26);
	assign t3 = (c >> 21) | (d << 11);
	assign t4 = (c >> 27) | (d << 5);

	assign word_new = a ^ t1 ^ ~(t2 & t3) ^ t4 ^ key_word;

endmodule

// ===== rtl/knp_seq.sv =====
module knp_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [knp_pkg::RoundW-1:0]  round_count,
	input  logic [1:0]                  key_size,
	output logic                        busy,
	output knp_pkg::seq_ctl_t           ctl
);
	import knp_pkg::*;

	seq_state_t         state_q, state_d;
	logic [RoundW-1:0]  rounds_q, rounds_d;
	logic [PhaseW-1:0]  phase_q, phase_d;
	logic [KeyIdxW-1:0] kidx_q, kidx_d;
	logic               done_q, done_d;
	logic [KeyIdxW-1:0] last_kidx;
	logic [RoundW-1:0]  rounds_dec;

	always_comb begin
		case (key_size)
			KEY_128: last_kidx = LAST_KEY_128;
			KEY_192: last_kidx = LAST_KEY_192;
			default: last_kidx = LAST_KEY_256;
		endcase
	end

	assign rounds_dec = rounds_q - RoundW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rounds_q <= '0;
			phase_q  <= '0;
			kidx_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rounds_q <= rounds_d;
			phase_q  <= phase_d;
			kidx_q   <= kidx_d;
			done_q   <= done_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rounds_d    = rounds_q;
		phase_d     = phase_q;
		kidx_d      = kidx_q;
		done_d      = 1'b0;
		ctl.load    = 1'b0;
		ctl.step    = 1'b0;
		ctl.done    = done_q;
		ctl.phase   = phase_q;
		ctl.key_idx = kidx_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_RUN;
					rounds_d = round_count;
					phase_d  = '0;
					kidx_d   = '0;
				end
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				phase_d  = phase_q + PhaseW'(1);
				kidx_d   = (kidx_q >= last_kidx) ? '0 : kidx_q + KeyIdxW'(1);
				// round ends after the fourth pass; zero count wraps to 256 rounds
				if (phase_q == PhaseW'(NumWords - 1)) begin
					rounds_d = rounds_dec;
					if (rounds_dec == '0) begin
						state_d = ST_IDLE;
						done_d  = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q == ST_RUN);

endmodule

// ===== rtl/keyed_nlfsr_permutation.sv =====
// Keyed NLFSR permutation of a 128-bit state. An item is taken when start is high and busy is
// low; the block then runs one 32-step pass per clock through a single shared feedback unit,
// four passes per round, with busy high while the item runs (a round count of 0 means
// 256 rounds), and once the last pass is done the result appears with done high
// for exactly one cycle right after. The receiver cannot stall: the result must be taken in
// that cycle. A new item may be started in the cycle that done is high. Key registers are
// written through cfg_we/cfg_index/cfg_data and must only change while busy is low.
module keyed_nlfsr_permutation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic                        cfg_we,
	input  logic [knp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [knp_pkg::CfgW-1:0]    cfg_data,
	input  logic [63:0]                 state_in_low,
	input  logic [63:0]                 state_in_high,
	input  logic [7:0]                  round_count,
	output logic [63:0]                 state_out_low,
	output logic [63:0]                 state_out_high
);
	import knp_pkg::*;

	logic [1:0] key_size_q;
	word_t      key_q [MaxKeyWords];
	word_t      work_q [NumWords];
	word_t      word_new;
	seq_ctl_t   ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			key_q      <= '{default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				CFG_KEY_A: begin
					key_q[0] <= cfg_data[31:0];
					key_q[1] <= cfg_data[63:32];
				end
				CFG_KEY_B: begin
					key_q[2] <= cfg_data[31:0];
					key_q[3] <= cfg_data[63:32];
				end
				CFG_KEY_C: begin
					key_q[4] <= cfg_data[31:0];
					key_q[5] <= cfg_data[63:32];
				end
				CFG_KEY_D: begin
					key_q[6] <= cfg_data[31:0];
					key_q[7] <= cfg_data[63:32];
				end
				default: ;
			endcase
		end
	end

	knp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.round_count (round_count),
		.key_size    (key_size_q),
		.busy        (busy),
		.ctl         (ctl)
	);

	knp_pass u_pass (
		.word0    (work_q[0]),
		.word1    (work_q[1]),
		.word2    (work_q[2]),
		.word3    (work_q[3]),
		.phase    (ctl.phase),
		.key_word (key_q[ctl.key_idx]),
		.word_new (word_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '{default: '0};
		end else if (ctl.load) begin
			work_q[0] <= state_in_low[31:0];
			work_q[1] <= state_in_low[63:32];
			work_q[2] <= state_in_high[31:0];
			work_q[3] <= state_in_high[63:32];
		end else if (ctl.step) begin
			work_q[ctl.phase] <= word_new;
		end
	end

	assign done           = ctl.done;
	assign state_out_low  = {work_q[1], work_q[0]};
	assign state_out_high = {work_q[3], work_q[2]};

endmodule
